// ----- hdl/battery_peak_hold_filter_assert.svh -----
// Assertion macros shared by the battery peak hold filter RTL.
`ifndef BATTERY_PEAK_HOLD_FILTER_ASSERT_SVH
`define BATTERY_PEAK_HOLD_FILTER_ASSERT_SVH

// Same-cycle implication, checked at every rising clk edge out of reset.
`define BPHF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bphf assertion failed");

// Next-cycle implication.
`define BPHF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bphf assertion failed");

`endif

// ----- hdl/bphf_pkg.sv -----
// Package: shared types, register indexes and reset values of the battery peak hold filter.
package bphf_pkg;

	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned RUN_W     = 8;
	localparam int unsigned WINDOW_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NOISE_THRESHOLD      = 2'd0,
		CFG_OUTLIER_ACCEPT_COUNT = 2'd1,
		CFG_WINDOW_LENGTH        = 2'd2
	} cfg_idx_t;

	localparam logic [LEVEL_W-1:0]  NOISE_THRESHOLD_RST      = 8'd5;
	localparam logic [RUN_W-1:0]    OUTLIER_ACCEPT_COUNT_RST = 8'd3;
	localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RST        = 16'd1000;

	typedef struct packed {
		logic [LEVEL_W-1:0]  noise_threshold;
		logic [RUN_W-1:0]    outlier_accept_count;
		logic [WINDOW_W-1:0] window_length;
	} cfg_t;

	// One filter step as seen by the window tracker.
	typedef struct packed {
		logic                step;
		logic [SAMPLE_W-1:0] sample;
		logic [LEVEL_W-1:0]  smooth_next;
	} step_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] reported_level;
		logic               window_end;
	} window_res_t;

endpackage

// ----- hdl/bphf_if.sv -----
// Valid/ready channel interfaces for sample words and level words.
interface bphf_in_if import bphf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface bphf_out_if import bphf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] reported_level;
	logic [LEVEL_W-1:0] smoothed_level;
	logic               window_end;

	modport source (output valid, output reported_level, output smoothed_level,
		output window_end, input ready);
	modport sink   (input valid, input reported_level, input smoothed_level,
		input window_end, output ready);
endinterface

// ----- hdl/battery_peak_hold_filter.sv -----
// Battery peak hold filter top level: input stage, smoother, window tracker, result register.
// Takes one 8-bit ADC sample per word and returns one result word per sample. The first
// sample seeds a smoothed value; later samples strictly inside +/- noise_threshold of it
// blend in as (9*old + sample)/10, others bump a wrapping outlier run and blend in only
// when the run hits outlier_accept_count. The maximum smoothed value over each window of
// window_length samples becomes the held level; reported_level is the raw sample until the
// first window closes and the held level after that. Throughput is one word per clock when
// levels.ready does not stall; a word passes the sample register, then the smoother/window
// update and the result register. The smoother state feeds back onto itself within that one
// update stage, which is what sets the single-cycle rate. The user must write configuration
// only while the block is idle, which it does not enforce; writes to unused indexes are ignored.
module battery_peak_hold_filter import bphf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bphf_in_if.sink               samples,
	bphf_out_if.source            levels,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data
);
`include "battery_peak_hold_filter_assert.svh"

	cfg_t        cfg;
	step_t       st;
	window_res_t wres;

	// Input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// Result register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] reported_q;
	logic [LEVEL_W-1:0] smoothed_q;
	logic               window_end_q;

	logic advance;      // result register free or being drained
	logic step;         // stage 1 word commits to state this cycle
	logic [LEVEL_W-1:0] smooth_next;

	assign advance       = !out_valid_q || levels.ready;
	assign step          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	bphf_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	bphf_smoother u_smoother (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.sample      (sample_s1),
		.cfg         (cfg),
		.smooth_next (smooth_next)
	);

	assign st.step        = step;
	assign st.sample      = sample_s1;
	assign st.smooth_next = smooth_next;

	bphf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cfg    (cfg),
		.res    (wres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			reported_q   <= wres.reported_level;
			smoothed_q   <= smooth_next;
			window_end_q <= wres.window_end;
		end
	end

	assign levels.valid          = out_valid_q;
	assign levels.reported_level = reported_q;
	assign levels.smoothed_level = smoothed_q;
	assign levels.window_end     = window_end_q;

	`BPHF_ASSERT_NEXT(a_step_gives_result, step, out_valid_q)
	`BPHF_ASSERT_NEXT(a_stall_holds_stage, valid_s1 && !advance, valid_s1 && $stable(sample_s1))

endmodule

// ----- hdl/bphf_cfg_regs.sv -----
// Configuration register file with a plain write port.
module bphf_cfg_regs import bphf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_threshold      <= NOISE_THRESHOLD_RST;
			cfg_q.outlier_accept_count <= OUTLIER_ACCEPT_COUNT_RST;
			cfg_q.window_length        <= WINDOW_LENGTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NOISE_THRESHOLD: begin
					cfg_q.noise_threshold <= cfg_wr_data[LEVEL_W-1:0];
				end
				CFG_OUTLIER_ACCEPT_COUNT: begin
					cfg_q.outlier_accept_count <= cfg_wr_data[RUN_W-1:0];
				end
				CFG_WINDOW_LENGTH: begin
					cfg_q.window_length <= cfg_wr_data[WINDOW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/bphf_smoother.sv -----
// Gated exponential smoother: seed, band check, outlier run and 9/10 blend.
module bphf_smoother import bphf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [SAMPLE_W-1:0] sample,
	input  cfg_t                cfg,
	output logic [LEVEL_W-1:0]  smooth_next
);
`include "battery_peak_hold_filter_assert.svh"

	localparam int unsigned SUM_W   = 12;  // 9*255 + 255 = 2550
	localparam int unsigned RECIP_W = 13;
	// floor(x/10) == (x*6554) >> 16 for x below 16384
	localparam logic [RECIP_W-1:0] RECIP_10 = 13'd6554;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam int unsigned SHIFT   = 16;

	logic [LEVEL_W-1:0] smooth_q;
	logic               seeded_q;
	logic [RUN_W-1:0]   run_q;

	logic [LEVEL_W-1:0] old_val;
	logic [9:0]         old_w, smp_w, th_w;
	logic               in_band;
	logic [RUN_W-1:0]   run_inc, run_next;
	logic               apply;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	logic [LEVEL_W-1:0] blended;

	// First sample seeds the value before the band check.
	assign old_val = seeded_q ? smooth_q : sample;

	// Strict band: old - th < s < old + th, done without signs.
	assign old_w   = {2'b00, old_val};
	assign smp_w   = {2'b00, sample};
	assign th_w    = {2'b00, cfg.noise_threshold};
	assign in_band = (smp_w < old_w + th_w) && (smp_w + th_w > old_w);

	assign run_inc  = run_q + RUN_W'(1);
	assign run_next = in_band ? '0 : run_inc;
	assign apply    = in_band || (run_inc == cfg.outlier_accept_count);

	assign sum     = {old_val, 3'b000} + SUM_W'(old_val) + SUM_W'(sample);
	assign prod    = PROD_W'(sum) * PROD_W'(RECIP_10);
	assign blended = prod[SHIFT +: LEVEL_W];

	assign smooth_next = apply ? blended : old_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			seeded_q <= 1'b0;
			run_q    <= '0;
		end else if (step) begin
			smooth_q <= smooth_next;
			seeded_q <= 1'b1;
			run_q    <= run_next;
		end
	end

	`BPHF_ASSERT_NEXT(a_seed_after_step, step, seeded_q)
	`BPHF_ASSERT_NOW(a_unseeded_clean, !seeded_q, (smooth_q == '0) && (run_q == '0))

endmodule

// ----- hdl/bphf_window.sv -----
// Windowed maximum of the smoothed value and the held battery level.
module bphf_window import bphf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  step_t       st,
	input  cfg_t        cfg,
	output window_res_t res
);
`include "battery_peak_hold_filter_assert.svh"

	logic [WINDOW_W-1:0] count_q;
	logic [LEVEL_W-1:0]  max_q;
	logic [LEVEL_W-1:0]  held_q;
	logic                held_valid_q;

	logic [WINDOW_W-1:0] count_inc;
	logic [LEVEL_W-1:0]  max_upd;
	logic                close;

	assign count_inc = count_q + WINDOW_W'(1);
	assign close     = (count_inc == cfg.window_length);
	assign max_upd   = (st.smooth_next > max_q) ? st.smooth_next : max_q;

	// Level is picked from the held value before this word can close a window.
	assign res.reported_level = held_valid_q ? held_q : st.sample;
	assign res.window_end     = close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			max_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (st.step) begin
			if (close) begin
				count_q      <= '0;
				max_q        <= '0;
				held_q       <= max_upd;
				held_valid_q <= 1'b1;
			end else begin
				count_q <= count_inc;
				max_q   <= max_upd;
			end
		end
	end

	`BPHF_ASSERT_NEXT(a_close_clears, st.step && close,
		(count_q == '0) && (max_q == '0) && held_valid_q)
	`BPHF_ASSERT_NOW(a_max_covers_held_flag, !held_valid_q, held_q == '0)

endmodule
